[rtl/bbo_pkg.sv]
// shared constants and types for the bounding box overlap counter
`timescale 1ns / 1ps

package bbo_pkg;

    // store capacity and coordinate width
    localparam int MAX_FIGURES = 64;
    localparam int COORD_WIDTH = 16;

    // fixed field widths of the ports
    localparam int FIELD_W = 16;
    localparam int PAIR_W  = 11;

    localparam int IDX_W = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
    localparam int CNT_W = $clog2(MAX_FIGURES + 1);

    localparam logic [PAIR_W-1:0] PAIR_MAX = '1;
    localparam logic [CNT_W-1:0]  FIG_MAX  = CNT_W'(MAX_FIGURES);

    // figure jobs held between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result kinds
    localparam logic KIND_BOX   = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] left;
        logic signed [COORD_WIDTH-1:0] right;
        logic signed [COORD_WIDTH-1:0] top;
        logic signed [COORD_WIDTH-1:0] bottom;
    } t_box;

    typedef struct packed {
        t_box box;
        logic end_img;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_BOX,
        S_CNT
    } t_back_state;

endpackage

[rtl/bbo_front.sv]
// front part: takes vertices, tracks the running box, hands closed figures on
`timescale 1ns / 1ps

module bbo_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bbo_pkg::FIELD_W-1:0]  i_point_x,
    input  logic [bbo_pkg::FIELD_W-1:0]  i_point_y,
    input  logic                         i_end_of_figure,
    input  logic                         i_end_of_image,
    input  bbo_pkg::t_q_stat             i_q_stat,
    output logic                         o_push,
    output bbo_pkg::t_job                o_job
);
    import bbo_pkg::*;

    logic                          r_pending;
    t_box                          r_box;
    t_box                          n_box;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic                          accept;
    logic                          end_fig;

    assign x       = i_point_x[COORD_WIDTH-1:0];
    assign y       = i_point_y[COORD_WIDTH-1:0];
    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !o_stall;
    assign end_fig = i_end_of_figure || i_end_of_image;

    always_comb begin
        if (r_pending) begin
            n_box.left   = x;
            n_box.right  = x;
            n_box.top    = y;
            n_box.bottom = y;
        end else begin
            n_box.left   = (x < r_box.left)   ? x : r_box.left;
            n_box.right  = (x > r_box.right)  ? x : r_box.right;
            n_box.top    = (y > r_box.top)    ? y : r_box.top;
            n_box.bottom = (y < r_box.bottom) ? y : r_box.bottom;
        end
    end

    assign o_push      = accept && end_fig;
    assign o_job.box     = n_box;
    assign o_job.end_img = i_end_of_image;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b1;
        end else if (accept) begin
            r_pending <= end_fig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_box <= n_box;
        end
    end

endmodule

[rtl/bbo_queue.sv]
// short job queue between the front and back parts
`timescale 1ns / 1ps

module bbo_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bbo_pkg::t_job     i_job,
    input  logic              i_pop,
    output bbo_pkg::t_job     o_job,
    output bbo_pkg::t_q_stat  o_stat
);
    import bbo_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[rtl/bbo_back.sv]
// back part: walks the box store, counts overlaps, drives the result register
`timescale 1ns / 1ps

module bbo_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bbo_pkg::t_job                i_job,
    input  bbo_pkg::t_q_stat             i_q_stat,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_result_kind,
    output logic [bbo_pkg::FIELD_W-1:0]  o_box_left,
    output logic [bbo_pkg::FIELD_W-1:0]  o_box_right,
    output logic [bbo_pkg::FIELD_W-1:0]  o_box_top,
    output logic [bbo_pkg::FIELD_W-1:0]  o_box_bottom,
    output logic [bbo_pkg::PAIR_W-1:0]   o_pair_count,
    output logic                         o_figures_dropped,
    output logic                         o_final_result
);
    import bbo_pkg::*;

    function automatic logic [FIELD_W-1:0] coord_out(input logic [COORD_WIDTH-1:0] v);
        logic [FIELD_W-1:0] r;
        r = '0;
        r[COORD_WIDTH-1:0] = v;
        return r;
    endfunction

    function automatic logic overlap(input t_box a, input t_box b);
        return (a.left <= b.right) && (b.left <= a.right) &&
               (a.bottom <= b.top) && (b.bottom <= a.top);
    endfunction

    t_back_state       r_state;
    t_back_state       n_state;
    t_job              r_job;
    logic [CNT_W-1:0]  r_fig_cnt;
    logic [CNT_W-1:0]  r_idx;
    logic [PAIR_W-1:0] r_total;
    logic              r_ovf;
    t_box              r_mem [MAX_FIGURES];
    t_box              r_rd_data;
    logic              r_rd_vld;
    logic              r_out_vld;

    logic out_free;
    logic rd_en;
    logic wr_en;
    logic load_box;
    logic load_cnt;
    logic has_room;
    logic hit;

    assign out_free = !r_out_vld || !i_stall;
    assign has_room = (r_fig_cnt < FIG_MAX);
    assign hit      = r_rd_vld && overlap(r_rd_data, r_job.box);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = has_room ? S_WALK : S_BOX;
                end
            end
            S_WALK: begin
                if (r_idx == r_fig_cnt) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_BOX;
            S_BOX: begin
                if (out_free) begin
                    n_state = r_job.end_img ? S_CNT : S_IDLE;
                end
            end
            S_CNT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop    = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        load_box = 1'b0;
        load_cnt = 1'b0;
        unique case (r_state)
            S_IDLE:  o_pop    = !i_q_stat.empty;
            S_WALK:  rd_en    = (r_idx != r_fig_cnt);
            S_DRAIN: wr_en    = 1'b1;
            S_BOX:   load_box = out_free;
            S_CNT:   load_cnt = out_free;
            default: o_pop    = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fig_cnt <= '0;
            r_idx     <= '0;
            r_total   <= '0;
            r_ovf     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (o_pop) begin
                r_idx <= '0;
                if (!has_room) begin
                    r_ovf <= 1'b1;
                end
            end
            if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (hit && (r_total != PAIR_MAX)) begin
                r_total <= r_total + 1'b1;
            end
            if (wr_en) begin
                r_fig_cnt <= r_fig_cnt + 1'b1;
            end
            if (load_cnt) begin
                r_fig_cnt <= '0;
                r_total   <= '0;
                r_ovf     <= 1'b0;
            end
            if (load_box || load_cnt) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // job register, box store and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
        if (wr_en) begin
            r_mem[r_fig_cnt[IDX_W-1:0]] <= r_job.box;
        end
        if (load_box) begin
            o_result_kind     <= KIND_BOX;
            o_box_left        <= coord_out(r_job.box.left);
            o_box_right       <= coord_out(r_job.box.right);
            o_box_top         <= coord_out(r_job.box.top);
            o_box_bottom      <= coord_out(r_job.box.bottom);
            o_pair_count      <= '0;
            o_figures_dropped <= 1'b0;
            o_final_result    <= !r_job.end_img;
        end else if (load_cnt) begin
            o_result_kind     <= KIND_COUNT;
            o_box_left        <= '0;
            o_box_right       <= '0;
            o_box_top         <= '0;
            o_box_bottom      <= '0;
            o_pair_count      <= r_total;
            o_figures_dropped <= r_ovf;
            o_final_result    <= 1'b1;
        end
    end

    assign o_valid = r_out_vld;

endmodule

[rtl/bounding_box_overlap_counter_unit.sv]
// top level of the bounding box overlap counter
`timescale 1ns / 1ps

// Vertices enter one per cycle unless stalled. The front part keeps the
// running min/max box of the current figure and, on the last vertex of a
// figure, hands the box and the end-of-image mark to a two-entry job queue.
// The back part takes one job at a time: it reads every box already stored
// for the image through the single read port of the box store (one box a
// cycle), counts the overlapping pairs (closed intervals, so shared edges
// and nesting count), stores the new box and then gives the box result,
// followed by the pair count result on an image end. The walk covers the
// boxes stored so far in the image, at most 64. The input is stalled, for
// every vertex alike, while both queue entries hold figures that the back
// part has not yet taken. Figures beyond the store's capacity still give
// their box, take part in no pair and raise figures_dropped on the count.
// The pair count saturates at 2047. The store needs no clearing after
// reset, so the block takes items straight away.

module bounding_box_overlap_counter_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // vertex channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bbo_pkg::FIELD_W-1:0]  i_point_x,
    input  logic [bbo_pkg::FIELD_W-1:0]  i_point_y,
    input  logic                         i_end_of_figure,
    input  logic                         i_end_of_image,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_result_kind,
    output logic [bbo_pkg::FIELD_W-1:0]  o_box_left,
    output logic [bbo_pkg::FIELD_W-1:0]  o_box_right,
    output logic [bbo_pkg::FIELD_W-1:0]  o_box_top,
    output logic [bbo_pkg::FIELD_W-1:0]  o_box_bottom,
    output logic [bbo_pkg::PAIR_W-1:0]   o_pair_count,
    output logic                         o_figures_dropped,
    output logic                         o_final_result
);
    import bbo_pkg::*;

    // front to queue
    logic    push;
    t_job    push_job;
    // queue to back
    logic    pop;
    t_job    head_job;
    t_q_stat q_stat;

    // running box and figure closing
    bbo_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_end_of_figure (i_end_of_figure),
        .i_end_of_image  (i_end_of_image),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_job           (push_job)
    );

    // closed figures waiting for the store walk
    bbo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    // store walk, pair counting and result register
    bbo_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (head_job),
        .i_q_stat          (q_stat),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_result_kind     (o_result_kind),
        .o_box_left        (o_box_left),
        .o_box_right       (o_box_right),
        .o_box_top         (o_box_top),
        .o_box_bottom      (o_box_bottom),
        .o_pair_count      (o_pair_count),
        .o_figures_dropped (o_figures_dropped),
        .o_final_result    (o_final_result)
    );

endmodule
